FILE: rtl/indexed_insert_remove_list_unit_macros.svh
// Assertion macros used by the list unit top level.
`ifndef INDEXED_INSERT_REMOVE_LIST_UNIT_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ILRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ILRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ilru_pkg.sv
// Shared types and constants for the indexed insert/remove list unit.
package ilru_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int POS_W    = 7;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_UP   = 2'd2,
    CMD_DOWN = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    status_t status;
    count_t  count_nxt;
    logic    take_data;
  } ctrl_resp_t;

endpackage

FILE: rtl/ilru_cell.sv
// One list cell: holds a single entry and moves it to or from its neighbors.
module ilru_cell (
  input  logic                  clk,
  input  ilru_pkg::cell_cmd_t   cmd,
  input  ilru_pkg::word_t       left_i,
  input  ilru_pkg::word_t       right_i,
  input  ilru_pkg::word_t       new_i,
  output ilru_pkg::word_t       q_o
);
  import ilru_pkg::*;

  word_t value_r;
  word_t value_nxt;

  // Pick the source for this entry
  always_comb begin
    case (cmd)
      CMD_LOAD: value_nxt = new_i;
      CMD_UP:   value_nxt = left_i;
      CMD_DOWN: value_nxt = right_i;
      default:  value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign q_o = value_r;

endmodule

FILE: rtl/ilru_ctrl.sv
// Operation decode: range and full checks, new count and per-cell commands.
module ilru_ctrl (
  input  logic                                  accept,
  input  logic [1:0]                            opcode,
  input  logic [ilru_pkg::POS_W-1:0]            position,
  input  ilru_pkg::count_t                      count,
  output ilru_pkg::cell_cmd_t                   cmds [ilru_pkg::CAPACITY],
  output ilru_pkg::ctrl_resp_t                  resp
);
  import ilru_pkg::*;

  op_t  op;
  logic ins_range_bad;
  logic ins_full;
  logic ins_ok;
  logic idx_ok;
  logic rem_ok;

  assign op            = op_t'(opcode);
  assign ins_range_bad = POS_W'(count) < position;
  assign ins_full      = count >= CNT_W'(CAPACITY);
  assign idx_ok        = position < POS_W'(count);
  assign ins_ok        = (op == OP_INSERT) && !ins_range_bad && !ins_full;
  assign rem_ok        = (op == OP_REMOVE) && idx_ok;

  // Status, new count and whether an entry goes out
  always_comb begin
    resp.status    = ST_OK;
    resp.count_nxt = count;
    resp.take_data = 1'b0;
    case (op)
      OP_INSERT: begin
        if (ins_range_bad) begin
          resp.status = ST_RANGE;
        end else if (ins_full) begin
          resp.status = ST_FULL;
        end else begin
          resp.count_nxt = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!idx_ok) begin
          resp.status = ST_RANGE;
        end else begin
          resp.count_nxt = count - CNT_W'(1);
          resp.take_data = 1'b1;
        end
      end
      OP_READ: begin
        if (!idx_ok) begin
          resp.status = ST_RANGE;
        end else begin
          resp.take_data = 1'b1;
        end
      end
      default: begin
        resp.count_nxt = '0;
      end
    endcase
  end

  // Per-cell command: load at the position, shift the tail up or down
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmds[i] = CMD_HOLD;
      if (accept && ins_ok) begin
        if (POS_W'(i) == position) begin
          cmds[i] = CMD_LOAD;
        end else if (POS_W'(i) > position) begin
          cmds[i] = CMD_UP;
        end
      end else if (accept && rem_ok && (POS_W'(i) >= position)) begin
        cmds[i] = CMD_DOWN;
      end
    end
  end

endmodule

FILE: rtl/indexed_insert_remove_list_unit.sv
// Top level of the indexed insert/remove list unit.
// Ordered list of up to 64 signed 32-bit words held in a row of cells, one entry per
// cell. Every operation (insert, remove, read, clear) takes effect at the transfer edge: all
// cells shift or load together, and the result appears on the out_ channel in the cycle
// after the transfer, from an output register. One operation is taken per cycle;
// in_stall rises only while a finished result waits and out_stall is high. Flagged
// operations (index out of range, insert into a full list) leave the list unchanged
// and return data zero. Entries beyond the current length hold stale values.
module indexed_insert_remove_list_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic [ilru_pkg::POS_W-1:0]        in_position,
  input  logic signed [ilru_pkg::WORD_W-1:0] in_new_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ilru_pkg::WORD_W-1:0] out_data_out,
  output logic [ilru_pkg::CNT_W-1:0]        out_length,
  output logic [1:0]                        out_status
);
  import ilru_pkg::*;
  `include "indexed_insert_remove_list_unit_macros.svh"

  logic       accept;
  count_t     count_r;
  count_t     count_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  word_t      out_data_r;
  status_t    out_status_r;
  count_t     out_length_r;
  word_t      rd_word;
  cell_cmd_t  cmds [CAPACITY];
  word_t      cell_q [CAPACITY];
  ctrl_resp_t resp;

  // Accept a transfer unless a held result is stalled
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  ilru_ctrl u_ctrl (
    .accept   (accept),
    .opcode   (in_opcode),
    .position (in_position),
    .count    (count_r),
    .cmds     (cmds),
    .resp     (resp)
  );

  // Row of cells, each wired to its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_q[g+1];
    end
    ilru_cell u_cell (
      .clk     (clk),
      .cmd     (cmds[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .new_i   (in_new_value),
      .q_o     (cell_q[g])
    );
  end

  // Select the addressed entry before the shift takes effect
  assign rd_word = resp.take_data ? cell_q[in_position[IDX_W-1:0]] : '0;

  // Advance the count and the output valid
  always_comb begin
    count_nxt     = accept ? resp.count_nxt : count_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= rd_word;
      out_status_r <= resp.status;
      out_length_r <= resp.count_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_length   = out_length_r;
  assign out_status   = out_status_r;

  `ILRU_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `ILRU_ASSERT_NOW(a_len_tracks, out_valid_r, out_length_r == count_r, "length not count")
  `ILRU_ASSERT_NOW(a_full_len, out_valid_r && (out_status_r == ST_FULL),
                   out_length_r == CNT_W'(CAPACITY), "full flagged below capacity")
  `ILRU_ASSERT_NOW(a_flag_zero, out_valid_r && (out_status_r != ST_OK),
                   out_data_r == '0, "flagged result carries data")
  `ILRU_ASSERT_NEXT(a_clear, accept && (op_t'(in_opcode) == OP_CLEAR),
                    count_r == '0, "clear left entries")

endmodule

FILE: tb/sv/tb_indexed_insert_remove_list_unit.sv
// Self-checking testbench for the indexed insert/remove list unit.
module tb_indexed_insert_remove_list_unit;
  import ilru_pkg::*;

  localparam word_t WORD_MIN   = word_t'(32'h8000_0000);
  localparam word_t WORD_MAX   = word_t'(32'h7FFF_FFFF);
  localparam int    STUCK_MAX  = 2000;
  localparam int    MAX_POS    = (1 << POS_W) - 1;

  typedef struct {
    word_t   data;
    count_t  length;
    status_t status;
  } list_result_t;

  logic                     clk;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_opcode    = OP_READ;
  logic [POS_W-1:0]         in_position  = '0;
  logic signed [WORD_W-1:0] in_new_value = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic signed [WORD_W-1:0] out_data_out;
  logic [CNT_W-1:0]         out_length;
  logic [1:0]               out_status;

  // Shadow copy of the list contents, in order
  word_t        list_words[$];
  list_result_t expected_results[$];
  int           mismatch_count = 0;
  int           stuck_cycles   = 0;
  bit           calm_tail      = 1'b0;

  indexed_insert_remove_list_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_position  (in_position),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_length   (out_length),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow list and queue the result it gives
  function automatic void apply_list_op(op_t op, logic [POS_W-1:0] pos, word_t val);
    list_result_t res;
    int           idx;
    idx        = int'(pos);
    res.data   = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        // range check takes precedence over the full check
        if (idx > list_words.size()) res.status = ST_RANGE;
        else if (list_words.size() >= CAPACITY) res.status = ST_FULL;
        else list_words.insert(idx, val);
      end
      OP_REMOVE: begin
        if (idx >= list_words.size()) begin
          res.status = ST_RANGE;
        end else begin
          res.data = list_words[idx];
          list_words.delete(idx);
        end
      end
      OP_READ: begin
        if (idx >= list_words.size()) res.status = ST_RANGE;
        else res.data = list_words[idx];
      end
      default: list_words.delete();
    endcase
    res.length = count_t'(list_words.size());
    expected_results.push_back(res);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(11, 0))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '1;
      3: return '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Drive one operation, hold it until the transfer, then predict
  task automatic send_op(op_t op, int pos, word_t val);
    if (!calm_tail && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_position  <= POS_W'(pos);
    in_new_value <= val;
    do @(posedge clk); while (in_stall);
    apply_list_op(op, POS_W'(pos), val);
  endtask

  // Empty list, ends of the list, range errors and clear
  task automatic test_directed_edges();
    send_op(OP_READ, 0, '0);
    send_op(OP_REMOVE, 0, '0);
    send_op(OP_INSERT, 1, word_t'(5));
    send_op(OP_INSERT, 0, WORD_MIN);
    send_op(OP_INSERT, 1, WORD_MAX);
    send_op(OP_INSERT, 0, '1);
    send_op(OP_INSERT, 3, '0);
    send_op(OP_INSERT, 2, word_t'(32'h5555_AAAA));
    send_op(OP_READ, 0, '0);
    send_op(OP_READ, 4, '0);
    send_op(OP_READ, 5, '0);
    send_op(OP_READ, MAX_POS, '0);
    send_op(OP_INSERT, MAX_POS, word_t'(32'h1234_5678));
    send_op(OP_REMOVE, MAX_POS, '0);
    send_op(OP_REMOVE, 0, '0);
    send_op(OP_REMOVE, 3, '0);
    send_op(OP_REMOVE, 1, '0);
    send_op(OP_READ, 1, '0);
    send_op(OP_CLEAR, 7'h55, word_t'(32'hDEAD_BEEF));
    send_op(OP_READ, 0, '0);
    send_op(OP_CLEAR, MAX_POS, '1);
    send_op(OP_INSERT, 0, word_t'(32'h0F0F_0F0F));
  endtask

  // Fill to capacity, hit the full cases, then drain
  task automatic test_fill_to_capacity();
    send_op(OP_CLEAR, 0, '0);
    while (list_words.size() < CAPACITY)
      send_op(OP_INSERT, $urandom_range(list_words.size(), 0), pick_word());
    send_op(OP_INSERT, CAPACITY, pick_word());
    send_op(OP_INSERT, 0, pick_word());
    send_op(OP_INSERT, CAPACITY + 1, pick_word());
    send_op(OP_INSERT, MAX_POS, pick_word());
    send_op(OP_READ, CAPACITY - 1, '0);
    send_op(OP_READ, CAPACITY, '0);
    send_op(OP_REMOVE, CAPACITY, '0);
    send_op(OP_REMOVE, CAPACITY - 1, '0);
    send_op(OP_INSERT, CAPACITY - 1, pick_word());
    send_op(OP_READ, CAPACITY - 1, '0);
    while (list_words.size() > 0) begin
      if ($urandom_range(3, 0) == 0)
        send_op(OP_READ, $urandom_range(list_words.size() - 1, 0), '0);
      send_op(OP_REMOVE, $urandom_range(list_words.size() - 1, 0), pick_word());
    end
    send_op(OP_REMOVE, 0, '0);
  endtask

  // Steer the length toward random goals with some malformed operations mixed in
  task automatic test_random_walk(int unsigned n_ops);
    int unsigned k;
    int unsigned roll;
    int          fill;
    int          goal;
    op_t         op;
    int          pos;
    goal = $urandom_range(CAPACITY, 0);
    for (k = 0; k < n_ops; k++) begin
      fill = list_words.size();
      if (fill == goal || $urandom_range(40, 0) == 0) begin
        case ($urandom_range(3, 0))
          0: goal = 0;
          1: goal = CAPACITY;
          default: goal = $urandom_range(CAPACITY, 0);
        endcase
      end
      roll = $urandom_range(99, 0);
      if (roll < 8) begin
        op  = op_t'($urandom_range(3, 0));
        pos = $urandom_range(MAX_POS, 0);
      end else if (roll < 10) begin
        op  = OP_CLEAR;
        pos = $urandom_range(MAX_POS, 0);
      end else if (roll < 35 && fill > 0) begin
        op  = OP_READ;
        pos = $urandom_range(fill - 1, 0);
      end else if (fill < goal || fill == 0) begin
        op  = OP_INSERT;
        pos = $urandom_range(fill, 0);
      end else if (fill == CAPACITY && goal == CAPACITY) begin
        op  = OP_INSERT;
        pos = $urandom_range(fill, 0);
      end else begin
        op  = OP_REMOVE;
        pos = $urandom_range(fill - 1, 0);
      end
      send_op(op, pos, pick_word());
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_calm_tail(int unsigned n_ops);
    calm_tail = 1'b1;
    test_random_walk(n_ops);
  endtask

  // Output stall in random bursts, released for the tail
  initial begin : out_stall_gen
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (calm_tail) begin
        out_stall <= 1'b0;
      end else if (hold_left == 0) begin
        out_stall <= ($urandom_range(2, 0) == 0);
        hold_left = $urandom_range(7, 1);
      end else begin
        hold_left--;
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: data %0d length %0d status %0d",
                 $time, out_data_out, out_length, out_status);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_out !== want.data) begin
          $display("%0t: data expected %0d actual %0d", $time, want.data, out_data_out);
          mismatch_count++;
        end
        if (out_length !== want.length) begin
          $display("%0t: length expected %0d actual %0d", $time, want.length, out_length);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Stop the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("indexed_insert_remove_list_unit verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_fill_to_capacity();
    test_random_walk(1350);
    test_calm_tail(150);
    in_valid <= 1'b0;
    // Drain outstanding results, then let the output register settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("indexed_insert_remove_list_unit verification clean");
    end else begin
      $display("indexed_insert_remove_list_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: indexed_insert_remove_list_unit.f
+incdir+rtl
rtl/ilru_pkg.sv
rtl/ilru_cell.sv
rtl/ilru_ctrl.sv
rtl/indexed_insert_remove_list_unit.sv
tb/sv/tb_indexed_insert_remove_list_unit.sv
